### design/rgb_to_nv12_converter_unit_macros.svh
`ifndef RGB_TO_NV12_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_NV12_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTNV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTNV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/rtnv_pkg.sv
package rtnv_pkg;

   localparam int unsigned ROW_LIMIT = 4096;

   localparam logic [12:0] WIDTH_RESET  = 13'd1920;
   localparam logic [12:0] HEIGHT_RESET = 13'd1080;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [7:0] Y_COEF_R  = 8'd66;
   localparam logic [7:0] Y_COEF_G  = 8'd129;
   localparam logic [7:0] Y_COEF_B  = 8'd25;
   localparam logic [7:0] CB_COEF_R = 8'd38;
   localparam logic [7:0] CB_COEF_G = 8'd74;
   localparam logic [7:0] CB_COEF_B = 8'd112;
   localparam logic [7:0] CR_COEF_R = 8'd112;
   localparam logic [7:0] CR_COEF_G = 8'd94;
   localparam logic [7:0] CR_COEF_B = 8'd18;

   localparam logic [16:0] Y_ROUND   = 17'd128;
   localparam logic [8:0]  Y_OFFSET  = 9'd16;
   localparam logic [17:0] C_BIAS    = 18'd32896;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } pair_type;

   typedef struct packed {
      pixel_type  pixel;
      logic [7:0] avg_red;
      logic [7:0] avg_green;
      logic [7:0] avg_blue;
      logic       chroma_valid;
      logic       frame_end;
   } stage_type;

   function automatic logic [7:0] clamp8(input logic signed [17:0] value);
      logic [7:0] result;
      if (value < 0) begin
         result = 8'd0;
      end else if (value > 18'sd255) begin
         result = 8'd255;
      end else begin
         result = value[7:0];
      end
      return result;
   endfunction

endpackage

### design/rtnv_convert.sv
module rtnv_convert import rtnv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  stage_type   in_stage,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from the lowest bit up: luma, cb_value, cr_value.
   output logic [23:0] rsp_tdata,
   // Fields from the lowest bit up: chroma_valid.
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic        out_ready;

   logic        v2_ff, v2_in;
   logic [15:0] y_r_ff, y_g_ff, y_b_ff, y_r_in, y_g_in, y_b_in;
   logic [15:0] cb_r_ff, cb_g_ff, cb_b_ff, cb_r_in, cb_g_in, cb_b_in;
   logic [15:0] cr_r_ff, cr_g_ff, cr_b_ff, cr_r_in, cr_g_in, cr_b_in;
   logic        chroma2_ff, chroma2_in, fend2_ff, fend2_in;

   logic [16:0]        y_sum;
   logic [8:0]         luma_raw;
   logic signed [17:0] cb_sum, cr_sum;

   logic       vo_ff, vo_in;
   logic [7:0] luma_ff, luma_in, cb_ff, cb_in, cr_ff, cr_in;
   logic       chroma_ff, chroma_in, fend_ff, fend_in;

   assign out_ready = !vo_ff || rsp_tready;
   assign in_ready  = !v2_ff || out_ready;

   always_comb begin
      v2_in      = in_valid;
      y_r_in     = 16'(Y_COEF_R)  * 16'(in_stage.pixel.red);
      y_g_in     = 16'(Y_COEF_G)  * 16'(in_stage.pixel.green);
      y_b_in     = 16'(Y_COEF_B)  * 16'(in_stage.pixel.blue);
      cb_r_in    = 16'(CB_COEF_R) * 16'(in_stage.avg_red);
      cb_g_in    = 16'(CB_COEF_G) * 16'(in_stage.avg_green);
      cb_b_in    = 16'(CB_COEF_B) * 16'(in_stage.avg_blue);
      cr_r_in    = 16'(CR_COEF_R) * 16'(in_stage.avg_red);
      cr_g_in    = 16'(CR_COEF_G) * 16'(in_stage.avg_green);
      cr_b_in    = 16'(CR_COEF_B) * 16'(in_stage.avg_blue);
      chroma2_in = in_stage.chroma_valid;
      fend2_in   = in_stage.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (in_ready) begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         y_r_ff     <= y_r_in;
         y_g_ff     <= y_g_in;
         y_b_ff     <= y_b_in;
         cb_r_ff    <= cb_r_in;
         cb_g_ff    <= cb_g_in;
         cb_b_ff    <= cb_b_in;
         cr_r_ff    <= cr_r_in;
         cr_g_ff    <= cr_g_in;
         cr_b_ff    <= cr_b_in;
         chroma2_ff <= chroma2_in;
         fend2_ff   <= fend2_in;
      end
   end

   always_comb begin
      y_sum    = 17'(y_r_ff) + 17'(y_g_ff) + 17'(y_b_ff) + Y_ROUND;
      luma_raw = 9'(y_sum >> 8) + Y_OFFSET;
      cb_sum   = $signed(C_BIAS + 18'(cb_b_ff) - 18'(cb_r_ff) - 18'(cb_g_ff));
      cr_sum   = $signed(C_BIAS + 18'(cr_r_ff) - 18'(cr_g_ff) - 18'(cr_b_ff));
      vo_in     = v2_ff;
      luma_in   = clamp8($signed(18'(luma_raw)));
      cb_in     = chroma2_ff ? clamp8(cb_sum >>> 8) : 8'd0;
      cr_in     = chroma2_ff ? clamp8(cr_sum >>> 8) : 8'd0;
      chroma_in = chroma2_ff;
      fend_in   = fend2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (out_ready) begin
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         luma_ff   <= luma_in;
         cb_ff     <= cb_in;
         cr_ff     <= cr_in;
         chroma_ff <= chroma_in;
         fend_ff   <= fend_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {cr_ff, cb_ff, luma_ff};
   assign rsp_tuser  = chroma_ff;
   assign rsp_tlast  = fend_ff;

endmodule

### design/rgb_to_nv12_converter_unit.sv
// RGB to NV12 converter: BT.601 limited-range RGB to YCbCr 4:2:0 samples.
// Pixels enter on the req_ stream in raster order, one transfer per pixel, and
// each produces exactly one transfer on the rsp_ stream carrying its luma. On
// the last pixel of each 2x2 block tuser is set and the block's Cb and Cr
// ride along; tlast marks the last pixel of the frame. Frame size comes from
// the csr_ registers frame_width and frame_height, written while idle.
// Throughput is one pixel per cycle while the receiver accepts. On its way
// out a result passes the row store read, the product stage and the output
// register. The upper row of each row pair leaves its horizontal pair sums in
// a single-port-per-direction row store of (MAX_WIDTH+1)/2 entries, which
// the lower row reads back through a register that feeds the chroma math.
// When the receiver stalls, the pipeline holds and keeps accepting input until
// all three stages are full; req_tready then follows rsp_tready.
// Reset clears the pipeline, the row and column counters and the held pixel,
// and sets the registers to 1920 by 1080. The row store is not cleared and
// needs no clearing pass, since every entry is written before a read of it is used.
`include "rgb_to_nv12_converter_unit_macros.svh"

module rgb_to_nv12_converter_unit import rtnv_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from the lowest bit up: blue, green, red.
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from the lowest bit up: luma, cb_value, cr_value.
   output logic [23:0] rsp_tdata,
   // Fields from the lowest bit up: chroma_valid.
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int IW = (XW > 1) ? XW - 1 : 1;

   logic [12:0] width_ff, width_in, height_ff, height_in;
   logic        csr_write;

   logic [EW-1:0] width_eff;
   logic [12:0]   height_eff;

   logic [XW-1:0] column_ff, column_in;
   logic [11:0]   row_ff, row_in;
   pixel_type     held_ff, held_in;

   pixel_type     pix;
   logic          col_wrap;
   logic [12:0]   row_step;
   logic [XW-1:0] x;
   logic [11:0]   y;
   logic          x_last, y_last, hold, pair_done, chroma_now;
   pair_type      pair;
   logic [IW-1:0] idx;

   logic req_fire, en1, s2_ready, store_we;

   pair_type store_mem [STORE_DEPTH];
   pair_type store_rd_ff;

   logic      v1_ff, v1_in;
   pixel_type pix1_ff, pix1_in;
   pair_type  pair1_ff, pair1_in;
   logic      use_store1_ff, use_store1_in;
   logic      chroma1_ff, chroma1_in, fend1_ff, fend1_in;

   logic [9:0] sum_r, sum_g, sum_b;
   stage_type  stage1;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[12:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = {19'd0, width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      width_eff = EW'(MAX_WIDTH);
      if (width_ff == 13'd0) begin
         width_eff = EW'(1);
      end else if (32'(width_ff) <= 32'(MAX_WIDTH)) begin
         width_eff = EW'(width_ff);
      end
      height_eff = height_ff;
      if (height_ff == 13'd0) begin
         height_eff = 13'd1;
      end else if (32'(height_ff) > 32'(ROW_LIMIT)) begin
         height_eff = 13'(ROW_LIMIT);
      end
   end

   assign en1        = !v1_ff || s2_ready;
   assign req_tready = en1;
   assign req_fire   = req_tvalid && en1;
   assign pix        = req_tdata;

   always_comb begin
      col_wrap   = EW'(column_ff) >= width_eff;
      x          = col_wrap ? '0 : column_ff;
      row_step   = col_wrap ? 13'(row_ff) + 13'd1 : 13'(row_ff);
      y          = (row_step >= height_eff) ? 12'd0 : row_step[11:0];
      x_last     = (EW'(x) + EW'(1)) == width_eff;
      y_last     = (13'(y) + 13'd1) == height_eff;
      hold       = !x[0] && !x_last;
      pair_done  = !hold;
      chroma_now = pair_done && (y[0] || y_last);
      store_we   = req_fire && pair_done && !y[0] && !y_last;
      idx        = IW'(x >> 1);
      if (x[0]) begin
         pair.red   = 9'(held_ff.red)   + 9'(pix.red);
         pair.green = 9'(held_ff.green) + 9'(pix.green);
         pair.blue  = 9'(held_ff.blue)  + 9'(pix.blue);
      end else begin
         pair.red   = {pix.red, 1'b0};
         pair.green = {pix.green, 1'b0};
         pair.blue  = {pix.blue, 1'b0};
      end
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      if (req_fire) begin
         if (x_last) begin
            column_in = '0;
            row_in    = y_last ? 12'd0 : y + 12'd1;
         end else begin
            column_in = x + XW'(1);
            row_in    = y;
         end
         if (hold) begin
            held_in = pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= 12'd0;
         held_ff   <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[idx] <= pair;
      end
      if (en1) begin
         store_rd_ff <= store_mem[idx];
      end
   end

   always_comb begin
      v1_in         = req_tvalid;
      pix1_in       = pix;
      pair1_in      = pair;
      use_store1_in = y[0];
      chroma1_in    = chroma_now;
      fend1_in      = x_last && y_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pix1_ff       <= pix1_in;
         pair1_ff      <= pair1_in;
         use_store1_ff <= use_store1_in;
         chroma1_ff    <= chroma1_in;
         fend1_ff      <= fend1_in;
      end
   end

   // The lower row adds the stored upper pair; a lone last row counts twice.
   always_comb begin
      if (use_store1_ff) begin
         sum_r = 10'(pair1_ff.red)   + 10'(store_rd_ff.red);
         sum_g = 10'(pair1_ff.green) + 10'(store_rd_ff.green);
         sum_b = 10'(pair1_ff.blue)  + 10'(store_rd_ff.blue);
      end else begin
         sum_r = {pair1_ff.red, 1'b0};
         sum_g = {pair1_ff.green, 1'b0};
         sum_b = {pair1_ff.blue, 1'b0};
      end
      stage1.pixel        = pix1_ff;
      stage1.avg_red      = sum_r[9:2];
      stage1.avg_green    = sum_g[9:2];
      stage1.avg_blue     = sum_b[9:2];
      stage1.chroma_valid = chroma1_ff;
      stage1.frame_end    = fend1_ff;
   end

   rtnv_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v1_ff),
      .in_ready   (s2_ready),
      .in_stage   (stage1),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `RTNV_ASSERT_NEXT(a_column_wrap, clock, reset, req_fire && x_last, column_ff == '0, "column did not wrap")
   `RTNV_ASSERT_SAME(a_chroma_column, clock, reset, req_fire && chroma_now, x[0] || x_last, "chroma on wrong column")
   `RTNV_ASSERT_NEXT(a_stage1_hold, clock, reset, v1_ff && !s2_ready, v1_ff, "stalled item lost")
   `RTNV_ASSERT_SAME(a_chroma_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[23:8] == 16'd0, "chroma not zero")

endmodule
